// ===== rtl/websocket_frame_receiver_core_defines.svh =====
// Assertion macros shared by the frame receiver modules.
// Each macro expects the signals aclk and aresetn to be visible in the calling module.
`ifndef WEBSOCKET_FRAME_RECEIVER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define WSFR_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("wsfr assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define WSFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wsfr assertion failed");

`else

`define WSFR_ASSERT(label, prop)
`define WSFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/wsfr_pkg.sv =====
package wsfr_pkg;

    // Width of the held payload length; longer extended lengths saturate.
    localparam int LENGTH_BITS = 64;

    // Width of the extended length field as it arrives on the wire.
    localparam int EXT_LEN_W = 64;

    // Largest payload length that can be held.
    localparam logic [EXT_LEN_W-1:0] LEN_MAX_MASK =
        {EXT_LEN_W{1'b1}} >> (EXT_LEN_W - LENGTH_BITS);

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Byte counts that close the extended length and mask key fields.
    localparam logic [2:0] EXT16_DONE_COUNT = 3'd2;
    localparam logic [2:0] EXT64_DONE_COUNT = 3'd0;
    localparam logic [1:0] KEY_LAST_BYTE    = 2'd3;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_DATA
    } wsfr_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic [2:0] reserved_bits;
        logic       was_masked;
        logic       empty_frame;
        logic       last_of_frame;
    } wsfr_result_t;

endpackage

// ===== rtl/wsfr_parser.sv =====
`include "websocket_frame_receiver_core_defines.svh"

module wsfr_parser import wsfr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_fire,
    input  logic [7:0]   in_byte,
    output logic         res_valid,
    output wsfr_result_t res
);

    wsfr_phase_t            phase_reg, phase_next;
    logic [2:0]             count_reg, count_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   fin_reg, fin_next;
    logic [2:0]             rsv_reg, rsv_next;
    logic                   masked_reg, masked_next;
    logic [EXT_LEN_W-1:0]   acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [1:0]             offset_reg, offset_next;
    logic [3:0][7:0]        key_reg, key_next;

    logic                   hdr_done;
    logic [LENGTH_BITS-1:0] hdr_len;
    logic                   start_go;
    logic [LENGTH_BITS-1:0] start_len;
    logic                   emit_valid;
    logic                   emit_empty;
    logic                   emit_last;
    logic [7:0]             emit_data;
    logic [6:0]             len_code;

    assign len_code = in_byte[6:0];

    // Next-state logic: one header, length, key or payload byte per transaction.
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        rsv_next    = rsv_reg;
        masked_next = masked_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        offset_next = offset_reg;
        key_next    = key_reg;
        hdr_done    = 1'b0;
        hdr_len     = '0;
        start_go    = 1'b0;
        start_len   = remain_reg;
        emit_valid  = 1'b0;
        emit_empty  = 1'b0;
        emit_last   = 1'b0;
        emit_data   = '0;

        if (in_fire) begin
            case (phase_reg)
                PH_HDR0: begin
                    opcode_next = in_byte[3:0];
                    fin_next    = in_byte[7];
                    rsv_next    = in_byte[6:4];
                    masked_next = 1'b0;
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_next = in_byte[7];
                    key_next    = '0;
                    count_next  = '0;
                    acc_next    = '0;
                    if (len_code == LEN_CODE_EXT16) begin
                        phase_next = PH_EXT16;
                    end else if (len_code == LEN_CODE_EXT64) begin
                        phase_next = PH_EXT64;
                    end else begin
                        hdr_done = 1'b1;
                        hdr_len  = LENGTH_BITS'(len_code);
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    acc_next   = {acc_reg[EXT_LEN_W-9:0], in_byte};
                    count_next = count_reg + 3'd1;
                    if ((phase_reg == PH_EXT16 && count_next == EXT16_DONE_COUNT) ||
                        (phase_reg == PH_EXT64 && count_next == EXT64_DONE_COUNT)) begin
                        hdr_done = 1'b1;
                        // Lengths beyond the held width saturate.
                        if (|(acc_next & ~LEN_MAX_MASK)) begin
                            hdr_len = LEN_MAX_MASK[LENGTH_BITS-1:0];
                        end else begin
                            hdr_len = acc_next[LENGTH_BITS-1:0];
                        end
                    end
                end
                PH_MASK: begin
                    key_next[count_reg[1:0]] = in_byte;
                    if (count_reg[1:0] == KEY_LAST_BYTE) begin
                        count_next = '0;
                        start_go   = 1'b1;
                        start_len  = remain_reg;
                    end else begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_DATA: begin
                    offset_next = offset_reg + 2'd1;
                    remain_next = remain_reg - LENGTH_BITS'(1);
                    emit_valid  = 1'b1;
                    emit_data   = in_byte ^ key_reg[offset_reg];
                    emit_last   = (remain_reg == LENGTH_BITS'(1));
                    if (emit_last) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            // Header complete: collect the mask key or go straight to the payload.
            if (hdr_done) begin
                count_next  = '0;
                remain_next = hdr_len;
                if (masked_next) begin
                    phase_next = PH_MASK;
                end else begin
                    start_go  = 1'b1;
                    start_len = hdr_len;
                end
            end

            // Payload start: a zero-length frame closes at once with one empty result.
            if (start_go) begin
                offset_next = '0;
                remain_next = start_len;
                if (start_len == '0) begin
                    phase_next = PH_HDR0;
                    emit_valid = 1'b1;
                    emit_empty = 1'b1;
                    emit_last  = 1'b1;
                end else begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    // Result assembly from the header fields as they stand after this byte.
    always_comb begin
        res_valid          = emit_valid;
        res.data_byte      = emit_data;
        res.frame_opcode   = opcode_next;
        res.final_fragment = fin_next;
        res.reserved_bits  = rsv_next;
        res.was_masked     = masked_next;
        res.empty_frame    = emit_empty;
        res.last_of_frame  = emit_last;
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            count_reg  <= '0;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            rsv_reg    <= '0;
            masked_reg <= 1'b0;
            acc_reg    <= '0;
            remain_reg <= '0;
            offset_reg <= '0;
            key_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            rsv_reg    <= rsv_next;
            masked_reg <= masked_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            offset_reg <= offset_next;
            key_reg    <= key_next;
        end
    end

    // The first header byte never produces a result.
    `WSFR_ASSERT(a_no_result_on_hdr0, !(in_fire && phase_reg == PH_HDR0) || !res_valid)
    // An empty frame result always closes its frame.
    `WSFR_ASSERT(a_empty_is_last, !(res_valid && res.empty_frame) || res.last_of_frame)
    // In the payload phase there is always at least one byte left to take.
    `WSFR_ASSERT(a_data_has_bytes, phase_reg != PH_DATA || remain_reg != '0)
    // Taking the closing payload byte returns the parser to the first header byte.
    `WSFR_ASSERT_NEXT(a_last_to_hdr0, res_valid && res.last_of_frame, phase_reg == PH_HDR0)

endmodule

// ===== rtl/wsfr_out_buf.sv =====
`include "websocket_frame_receiver_core_defines.svh"

module wsfr_out_buf import wsfr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  wsfr_result_t in_res,
    output logic         space_ok,
    output logic         m_valid,
    input  logic         m_ready,
    output wsfr_result_t m_res
);

    logic         out_valid_reg;
    wsfr_result_t out_res_reg;
    logic         skid_valid_reg;
    wsfr_result_t skid_res_reg;

    // A new transaction is taken while the skid stage is free.
    assign space_ok = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_res_reg;

    // Output register with a one-entry skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_res_reg <= skid_res_reg;
            end else if (in_valid) begin
                out_res_reg <= in_res;
            end
        end else if (in_valid) begin
            skid_res_reg <= in_res;
        end
    end

    // The skid stage only fills behind a waiting result.
    `WSFR_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    // A drained output reloads from the skid stage and frees it.
    `WSFR_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_ready,
        out_valid_reg && !skid_valid_reg)
    // A result into an empty output register shows up there next cycle.
    `WSFR_ASSERT_NEXT(a_fill_empty, in_valid && !out_valid_reg,
        out_valid_reg && !skid_valid_reg)

endmodule

// ===== rtl/websocket_frame_receiver_core.sv =====
// WebSocket frame receiver: takes the received stream one byte per transaction and
// deframes base-framing headers (FIN, RSV1-3, opcode, mask flag, 7/16/64-bit length,
// optional 4-byte mask key). Every payload byte comes out unmasked with the frame's
// header fields, the last one flagged; a zero-length frame yields a single result flagged
// empty on its last header byte, and header bytes yield nothing. Throughput is one byte
// per clock while the skid stage is free: the parser updates its phase and applies the
// key combinationally, and an output register with a one-entry skid stage lets input
// continue while a result waits. Each result is registered. Extended lengths beyond the
// held length width saturate; opcodes and RSV bits pass through unchecked.
module websocket_frame_receiver_core import wsfr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic [3:0] m_frame_opcode,
    output logic       m_final_fragment,
    output logic [2:0] m_reserved_bits,
    output logic       m_was_masked,
    output logic       m_empty_frame,
    output logic       m_last_of_frame
);

    logic         in_fire;
    logic         res_valid;
    wsfr_result_t res;
    wsfr_result_t m_res;

    assign in_fire = s_valid && s_ready;

    // Frame parser.
    wsfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register and skid stage.
    wsfr_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .space_ok (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_data_byte      = m_res.data_byte;
    assign m_frame_opcode   = m_res.frame_opcode;
    assign m_final_fragment = m_res.final_fragment;
    assign m_reserved_bits  = m_res.reserved_bits;
    assign m_was_masked     = m_res.was_masked;
    assign m_empty_frame    = m_res.empty_frame;
    assign m_last_of_frame  = m_res.last_of_frame;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench import wsfr_pkg::*; ();

    // Ways of coding the payload length in the second header byte.
    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    localparam int HOLDOFF_AT      = 300;
    localparam int HOLDOFF_CYCLES  = 250;
    localparam int DRAIN_AT        = 550;
    localparam int RANDOM_BYTES    = 650;
    localparam int MAX_REPORTS     = 10;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data_byte;
    logic [3:0] m_frame_opcode;
    logic       m_final_fragment;
    logic [2:0] m_reserved_bits;
    logic       m_was_masked;
    logic       m_empty_frame;
    logic       m_last_of_frame;

    websocket_frame_receiver_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data_byte      (m_data_byte),
        .m_frame_opcode   (m_frame_opcode),
        .m_final_fragment (m_final_fragment),
        .m_reserved_bits  (m_reserved_bits),
        .m_was_masked     (m_was_masked),
        .m_empty_frame    (m_empty_frame),
        .m_last_of_frame  (m_last_of_frame)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stream bytes waiting to be sent and deframed bytes waiting to be seen.
    logic [7:0]   pending_bytes[$];
    wsfr_result_t expected_results[$];

    int items_accepted = 0;
    int total_items = 0;
    int results_checked = 0;
    int frames_closed = 0;
    int empty_frames_seen = 0;
    int mismatch_count = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    bit drain_done = 1'b0;

    // Deframer state, mirrored from the byte stream as it is accepted.
    wsfr_phase_t rx_phase = PH_HDR0;
    logic [2:0]  hdr_count = '0;
    logic [3:0]  cur_opcode = '0;
    logic [4:0]  cur_flags = '0;
    logic [63:0] frame_len = '0;
    logic [63:0] frame_pos = '0;
    logic [31:0] key_word = '0;

    // Flag bits kept in cur_flags beside RSV1..RSV3.
    localparam logic [4:0] FLAG_MASK = 5'h10;
    localparam logic [4:0] FLAG_FIN  = 5'h08;

    // Share of cycles, in percent, that one side idles in the current phase.
    function automatic int idle_share(input int accepted, input bit receiver_side);
        int sel;
        sel = (accepted / 96) % 4;
        case (sel)
            1: idle_share = receiver_side ? 0 : 49;
            2: idle_share = receiver_side ? 49 : 0;
            3: idle_share = 33;
            default: idle_share = 0;
        endcase
    endfunction

    task automatic push_result(input logic [7:0] data, input logic empty, input logic last);
        wsfr_result_t r;
        r.data_byte      = data;
        r.frame_opcode   = cur_opcode;
        r.final_fragment = (cur_flags & FLAG_FIN) != 0;
        r.reserved_bits  = cur_flags[2:0];
        r.was_masked     = (cur_flags & FLAG_MASK) != 0;
        r.empty_frame    = empty;
        r.last_of_frame  = last;
        expected_results = {expected_results, r};
    endtask

    // Header is complete: a zero length closes the frame right away.
    task automatic start_payload();
        frame_pos = '0;
        if (frame_len == 0) begin
            rx_phase = PH_HDR0;
            push_result(8'h00, 1'b1, 1'b1);
        end else begin
            rx_phase = PH_DATA;
        end
    endtask

    // Length field is complete: saturate it, then take the key if there is one.
    task automatic close_length();
        if (frame_len > LEN_MAX_MASK) begin
            frame_len = LEN_MAX_MASK;
        end
        hdr_count = '0;
        if ((cur_flags & FLAG_MASK) != 0) begin
            rx_phase = PH_MASK;
        end else begin
            start_payload();
        end
    endtask

    // Advance the mirrored deframer by one accepted byte.
    task automatic track_frame_byte(input logic [7:0] b);
        logic [7:0] key_byte;
        logic       last;
        case (rx_phase)
            PH_HDR1: begin
                if (b[7]) begin
                    cur_flags = cur_flags | FLAG_MASK;
                end
                key_word  = '0;
                hdr_count = '0;
                frame_len = '0;
                if (b[6:0] == LEN_CODE_EXT16) begin
                    rx_phase = PH_EXT16;
                end else if (b[6:0] == LEN_CODE_EXT64) begin
                    rx_phase = PH_EXT64;
                end else begin
                    frame_len = {57'd0, b[6:0]};
                    close_length();
                end
            end
            PH_EXT16, PH_EXT64: begin
                frame_len = {frame_len[55:0], b};
                hdr_count = hdr_count + 3'd1;
                if ((rx_phase == PH_EXT16 && hdr_count == EXT16_DONE_COUNT) ||
                    (rx_phase == PH_EXT64 && hdr_count == EXT64_DONE_COUNT)) begin
                    close_length();
                end
            end
            PH_MASK: begin
                key_word = key_word | ({24'd0, b} << (8 * hdr_count[1:0]));
                if (hdr_count[1:0] == KEY_LAST_BYTE) begin
                    hdr_count = '0;
                    start_payload();
                end else begin
                    hdr_count = hdr_count + 3'd1;
                end
            end
            PH_DATA: begin
                key_byte  = 8'(key_word >> (8 * frame_pos[1:0]));
                frame_pos = frame_pos + 64'd1;
                last      = frame_pos >= frame_len;
                if (last) begin
                    rx_phase = PH_HDR0;
                end
                push_result(b ^ key_byte, 1'b0, last);
            end
            default: begin
                cur_opcode = b[3:0];
                cur_flags  = {1'b0, b[7], b[6], b[5], b[4]};
                rx_phase   = PH_HDR1;
            end
        endcase
    endtask

    // Queue one frame: header, extended length, key and payload_count payload bytes.
    task automatic add_frame(input logic [7:0] hdr0, input bit masked, input len_form_t form,
                             input logic [63:0] len, input int payload_count);
        pending_bytes = {pending_bytes, hdr0};
        case (form)
            FORM_EXT16: begin
                pending_bytes = {pending_bytes, {masked, LEN_CODE_EXT16}};
                pending_bytes = {pending_bytes, len[15:8]};
                pending_bytes = {pending_bytes, len[7:0]};
            end
            FORM_EXT64: begin
                pending_bytes = {pending_bytes, {masked, LEN_CODE_EXT64}};
                for (int i = 7; i >= 0; i--) begin
                    pending_bytes = {pending_bytes, len[8*i +: 8]};
                end
            end
            default: begin
                pending_bytes = {pending_bytes, {masked, len[6:0]}};
            end
        endcase
        if (masked) begin
            for (int i = 0; i < 4; i++) begin
                pending_bytes = {pending_bytes, 8'($urandom_range(0, 255))};
            end
        end
        for (int i = 0; i < payload_count; i++) begin
            pending_bytes = {pending_bytes, 8'($urandom_range(0, 255))};
        end
    endtask

    // Driver: offers the next pending byte and tracks every accepted transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_in_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                track_frame_byte(s_in_byte);
                items_accepted <= items_accepted + 1;
            end
            // Once past the drain point, hold back until all results are out.
            if (!drain_done && items_accepted >= DRAIN_AT && expected_results.size() == 0) begin
                drain_done = 1'b1;
            end
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && (drain_done || items_accepted < DRAIN_AT) &&
                    $urandom_range(0, 99) >= idle_share(items_accepted, 1'b0)) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the block fills and pushes back on its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end else if (!holdoff_done && items_accepted >= HOLDOFF_AT) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // Monitor: compares every result transaction with the oldest expectation.
    always @(posedge aclk) begin : result_monitor
        wsfr_result_t got;
        wsfr_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_data_byte, m_frame_opcode, m_final_fragment, m_reserved_bits,
                       m_was_masked, m_empty_frame, m_last_of_frame};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result: data %h opcode %h fin %b rsv %b",
                                 got.data_byte, got.frame_opcode, got.final_fragment,
                                 got.reserved_bits);
                    end
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.last_of_frame) begin
                        frames_closed++;
                    end
                    if (want.empty_frame) begin
                        empty_frames_seen++;
                    end
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("result %0d mismatch (data opcode fin rsv masked empty last)",
                                     results_checked);
                            $display("  expected %h %h %b %b %b %b %b", want.data_byte,
                                     want.frame_opcode, want.final_fragment, want.reserved_bits,
                                     want.was_masked, want.empty_frame, want.last_of_frame);
                            $display("  actual   %h %h %b %b %b %b %b", got.data_byte,
                                     got.frame_opcode, got.final_fragment, got.reserved_bits,
                                     got.was_masked, got.empty_frame, got.last_of_frame);
                        end
                    end
                end
            end
            m_ready <= (holdoff_left == 0) &&
                       ($urandom_range(0, 99) >= idle_share(items_accepted, 1'b1));
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int sel;
        int code;
        logic [63:0] len;
        int start_size;

        // Directed frames: empty short, masked empty, RSV bits with no FIN, non-minimal
        // 16-bit length, empty 64-bit length, and a masked frame wrapping the key.
        add_frame(8'h81, 1'b0, FORM_SHORT, 64'd0, 0);
        add_frame(8'h8F, 1'b1, FORM_SHORT, 64'd0, 0);
        add_frame(8'h70, 1'b0, FORM_SHORT, 64'd1, 1);
        add_frame(8'h02, 1'b1, FORM_EXT16, 64'd2, 2);
        add_frame(8'h88, 1'b0, FORM_EXT64, 64'd0, 0);
        add_frame(8'hFA, 1'b1, FORM_SHORT, 64'd5, 5);

        // Random well-formed frames with random header bits, keys and payloads.
        start_size = pending_bytes.size();
        while (pending_bytes.size() - start_size < RANDOM_BYTES) begin
            sel = $urandom_range(0, 39);
            if (sel < 26) begin
                code = $urandom_range(0, 12);
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), FORM_SHORT,
                          64'(code), code);
            end else if (sel < 30) begin
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), FORM_SHORT,
                          64'd0, 0);
            end else if (sel == 30) begin
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), FORM_SHORT,
                          64'd125, 125);
            end else if (sel < 36) begin
                len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(126, 300))
                                                  : 64'($urandom_range(0, 20));
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), FORM_EXT16,
                          len, int'(len));
            end else begin
                len = 64'($urandom_range(0, 20));
                add_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), FORM_EXT64,
                          len, int'(len));
            end
        end

        // Oversized 64-bit length with every bit set; the frame stays open to the end.
        add_frame(8'h82, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 40);
        total_items = pending_bytes.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted != total_items) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Deframed %0d stream bytes into %0d results checked, %0d frames closed.",
                 items_accepted, results_checked, frames_closed);
        $display("Covered %0d empty frames, a long output hold-off and a full drain pause.",
                 empty_frames_seen);
        if (mismatch_count == 0) begin
            $display("websocket_frame_receiver_core regression: pass");
        end else begin
            $display("%0d mismatches in total.", mismatch_count);
            $display("websocket_frame_receiver_core regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("Timed out with %0d of %0d bytes accepted, %0d results outstanding.",
                 items_accepted, total_items, expected_results.size());
        $display("websocket_frame_receiver_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wsfr_pkg.sv
rtl/wsfr_parser.sv
rtl/wsfr_out_buf.sv
rtl/websocket_frame_receiver_core.sv
dv/testbench.sv
